/* sv/rsi_pkg.sv */
// shared types, widths and constants for the ray/sphere intersection pipeline
package rsi_pkg;

  localparam int CoordW  = 32;   // input coordinate width
  localparam int RadW    = 31;   // radius width
  localparam int DistW   = 32;   // output distance width
  localparam int LimbW   = 32;   // multiplier limb width
  localparam int DiffW   = CoordW + 1;        // origin minus centre
  localparam int SqW     = 2 * CoordW - 1;    // one squared direction term
  localparam int DlW     = CoordW + DiffW;    // one direction times difference term
  localparam int LlTermW = 2 * DiffW - 1;     // one squared difference term
  localparam int RrW     = 2 * RadW;          // squared radius
  localparam int AW      = 2 * CoordW;        // a = D.D
  localparam int HW      = DlW + 2;           // h = D.L, signed
  localparam int LlW     = LlTermW + 1;       // L.L
  localparam int MulW    = HW;                // multiplier operand width
  localparam int ProdW   = 2 * MulW;          // multiplier product width
  localparam int DiscW   = ProdW + 2;         // signed discriminant
  localparam int RadicW  = 2 * (2 * CoordW - 1); // discriminant magnitude bound
  localparam int RootW   = RadicW / 2;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] origin_z;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] dir_z;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic [RadW-1:0]          sphere_radius;
  } ray_t;

  typedef struct packed {
    logic             hit;
    logic [DistW-1:0] distance;
  } res_t;

  // flags and operands carried alongside the two wide products
  typedef struct packed {
    logic            a_zero;
    logic            h_pos;
    logic            h_neg;
    logic            c_pos;
    logic            c_neg;
    logic [MulW-1:0] habs;
    logic [AW-1:0]   a;
  } pre_t;

  // carried through the square root
  typedef struct packed {
    logic            miss;
    logic            near;
    logic            h_neg;
    logic [MulW-1:0] habs;
    logic [AW-1:0]   a;
  } sq_side_t;

  // carried through the final square and the distance search
  typedef struct packed {
    logic          miss;
    logic [AW-1:0] a;
  } dist_side_t;

endpackage

/* sv/rsi_if.sv */
// valid/ready channels for rays in and intersection results out
interface rsi_ray_if;
  logic          valid;
  logic          ready;
  rsi_pkg::ray_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsi_res_if;
  logic          valid;
  logic          ready;
  rsi_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/rsi_mul.sv */
// three-stage unsigned multiplier built from 32 by 32 limb products
module rsi_mul #(
  parameter int W  = rsi_pkg::MulW,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          v_i,
  input  logic [W-1:0]  x_i,
  input  logic [W-1:0]  y_i,
  input  logic [SW-1:0] side_i,
  output logic          v_o,
  output logic [2*W-1:0] p_o,
  output logic [SW-1:0] side_o
);
  import rsi_pkg::*;

  localparam int NL   = (W + LimbW - 1) / LimbW;
  localparam int XW   = NL * LimbW;
  localparam int RowW = XW + LimbW;

  logic [XW-1:0]        xe, ye;
  logic [2*LimbW-1:0]   pp_q [NL][NL];
  logic [RowW-1:0]      row_d [NL];
  logic [RowW-1:0]      row_q [NL];
  logic [2*XW-1:0]      p_d;
  logic [2*W-1:0]       p_q;
  logic [2:0]           v_q;
  logic [SW-1:0]        side_q [3];

  assign xe = XW'(x_i);
  assign ye = XW'(y_i);

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NL; i++) begin
        for (int j = 0; j < NL; j++) begin
          pp_q[i][j] <= xe[i*LimbW +: LimbW] * ye[j*LimbW +: LimbW];
        end
      end
    end
  end

  // one row per limb of x
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NL; j++) begin
        row_d[i] = row_d[i] + (RowW'(pp_q[i][j]) << (j * LimbW));
      end
    end
  end

  always_comb begin
    p_d = '0;
    for (int i = 0; i < NL; i++) begin
      p_d = p_d + ((2 * XW)'(row_q[i]) << (i * LimbW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q     <= row_d;
      p_q       <= p_d[2*W-1:0];
      side_q[0] <= side_i;
      side_q[1] <= side_q[0];
      side_q[2] <= side_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], v_i};
    end
  end

  assign v_o    = v_q[2];
  assign p_o    = p_q;
  assign side_o = side_q[2];
endmodule

/* sv/rsi_sqrt.sv */
// pipelined floor square root, one root bit per stage
module rsi_sqrt #(
  parameter int RW = rsi_pkg::RadicW,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            v_i,
  input  logic [RW-1:0]   rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            v_o,
  output logic [RW/2-1:0] root_o,
  output logic [SW-1:0]   side_o
);
  localparam int QW = RW / 2;
  localparam int TW = RW + 2;

  logic [TW-1:0] rem_q  [QW];
  logic [QW-1:0] root_q [QW];
  logic [SW-1:0] side_q [QW];
  logic [QW-1:0] v_q;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [TW-1:0] rem_in;
    logic [TW-1:0] trial;
    logic [QW-1:0] root_in;
    logic [SW-1:0] side_in;
    logic          v_in;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = TW'(rad_i);
      assign root_in = '0;
      assign side_in = side_i;
      assign v_in    = v_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end

    // (4r + 1) << 2b, the cost of setting bit b of the root
    assign trial = TW'({root_in, 2'b01}) << (2 * (QW - 1 - k));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? rem_in - trial : rem_in;
        root_q[k] <= {root_in[QW-2:0], take};
        side_q[k] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end
  end

  assign v_o    = v_q[QW-1];
  assign root_o = root_q[QW-1];
  assign side_o = side_q[QW-1];
endmodule

/* sv/rsi_dist.sv */
// pipelined search for the largest d with d*d*a <= n2, one bit of d per stage
module rsi_dist #(
  parameter int NW = rsi_pkg::ProdW,
  parameter int AW = rsi_pkg::AW,
  parameter int DW = rsi_pkg::DistW,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          v_i,
  input  logic [NW-1:0] n2_i,
  input  logic [AW-1:0] a_i,
  input  logic [SW-1:0] side_i,
  output logic          v_o,
  output logic [DW-1:0] dist_o,
  output logic [SW-1:0] side_o
);
  localparam int CW = ((NW > AW + 2 * DW) ? NW : AW + 2 * DW) + 1;
  localparam int YW = AW + DW;

  // rem holds n2 - d*d*a, y holds d*a
  logic [CW-1:0] rem_q  [DW];
  logic [YW-1:0] y_q    [DW];
  logic [DW-1:0] d_q    [DW];
  logic [AW-1:0] a_q    [DW];
  logic [SW-1:0] side_q [DW];
  logic [DW-1:0] v_q;

  for (genvar k = 0; k < DW; k++) begin : g_stage
    localparam int B = DW - 1 - k;
    logic [CW-1:0] rem_in;
    logic [CW-1:0] trial;
    logic [YW-1:0] y_in;
    logic [DW-1:0] d_in;
    logic [AW-1:0] a_in;
    logic [SW-1:0] side_in;
    logic          v_in;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = CW'(n2_i);
      assign y_in    = '0;
      assign d_in    = '0;
      assign a_in    = a_i;
      assign side_in = side_i;
      assign v_in    = v_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign y_in    = y_q[k-1];
      assign d_in    = d_q[k-1];
      assign a_in    = a_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end

    // (d + 2^b)^2 a - d^2 a = 2^(b+1) d a + 2^(2b) a
    assign trial = (CW'(y_in) << (B + 1)) + (CW'(a_in) << (2 * B));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? rem_in - trial : rem_in;
        y_q[k]    <= take ? y_in + (YW'(a_in) << B) : y_in;
        d_q[k]    <= d_in | (DW'(take) << B);
        a_q[k]    <= a_in;
        side_q[k] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end
  end

  assign v_o    = v_q[DW-1];
  assign dist_o = d_q[DW-1];
  assign side_o = side_q[DW-1];
endmodule

/* sv/ray_sphere_intersect_unit.sv */
// ray versus sphere intersection: top level of the pipeline
//
// Usage: rays arrive on the ray_i channel (origin, direction and sphere centre
// in signed fixed point, radius unsigned) and one result per ray leaves on res_o,
// in the same order. A result carries hit and the distance along the ray to
// the nearest forward crossing, saturated to all ones; a miss gives hit = 0
// and distance = 0.
// There are 108 register stages from the transfer of a ray to its result on
// res_o: four setup stages, three-stage limb multipliers for h^2 and a*c, a
// discriminant stage, 63 square root stages (one root bit each), a stage for
// the chosen root, a second three-stage multiplier, 32 distance search stages
// and the output register. Throughput is one ray per cycle while the output
// is not stalled. All stages advance together; they halt only while a result
// sits in the output register and res_o.ready is low, and then ray_i.ready
// is low too. Nothing in flight is lost or repeated. Reset clears every valid
// bit, so the pipeline starts empty and takes a ray in the first cycle after
// reset.
module ray_sphere_intersect_unit (
  input logic clk_i,
  input logic rst_ni,
  rsi_ray_if.sink   ray_i,
  rsi_res_if.source res_o
);
  import rsi_pkg::*;

  logic en;
  logic out_v_q;
  res_t out_q;

  assign en          = !out_v_q || res_o.ready;
  assign ray_i.ready = en;

  // stage 1: differences
  logic                     s1_v_q;
  logic signed [CoordW-1:0] s1_d_q [3];
  logic signed [DiffW-1:0]  s1_l_q [3];
  logic [RadW-1:0]          s1_r_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_d_q[0] <= ray_i.data.dir_x;
      s1_d_q[1] <= ray_i.data.dir_y;
      s1_d_q[2] <= ray_i.data.dir_z;
      s1_l_q[0] <= DiffW'(ray_i.data.origin_x) - DiffW'(ray_i.data.center_x);
      s1_l_q[1] <= DiffW'(ray_i.data.origin_y) - DiffW'(ray_i.data.center_y);
      s1_l_q[2] <= DiffW'(ray_i.data.origin_z) - DiffW'(ray_i.data.center_z);
      s1_r_q    <= ray_i.data.sphere_radius;
    end
  end

  // stage 2: per-axis products
  logic signed [2*CoordW-1:0] dd_d [3];
  logic signed [DlW-1:0]      dl_d [3];
  logic signed [2*DiffW-1:0]  ll_d [3];
  logic [RrW-1:0]             rr_d;
  logic                       s2_v_q;
  logic [SqW-1:0]             s2_dd_q [3];
  logic signed [DlW-1:0]      s2_dl_q [3];
  logic [LlTermW-1:0]         s2_ll_q [3];
  logic [RrW-1:0]             s2_rr_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dd_d[k] = s1_d_q[k] * s1_d_q[k];
      dl_d[k] = s1_d_q[k] * s1_l_q[k];
      ll_d[k] = s1_l_q[k] * s1_l_q[k];
    end
    rr_d = s1_r_q * s1_r_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s2_dd_q[k] <= dd_d[k][SqW-1:0];
        s2_dl_q[k] <= dl_d[k];
        s2_ll_q[k] <= ll_d[k][LlTermW-1:0];
      end
      s2_rr_q <= rr_d;
    end
  end

  // stage 3: dot products
  logic                 s3_v_q;
  logic [AW-1:0]        s3_a_q;
  logic signed [HW-1:0] s3_h_q;
  logic [LlW-1:0]       s3_ll_q;
  logic [RrW-1:0]       s3_rr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_a_q  <= AW'(s2_dd_q[0]) + AW'(s2_dd_q[1]) + AW'(s2_dd_q[2]);
      s3_h_q  <= HW'(s2_dl_q[0]) + HW'(s2_dl_q[1]) + HW'(s2_dl_q[2]);
      s3_ll_q <= LlW'(s2_ll_q[0]) + LlW'(s2_ll_q[1]) + LlW'(s2_ll_q[2]);
      s3_rr_q <= s2_rr_q;
    end
  end

  // stage 4: c, magnitudes and sign flags
  logic signed [MulW-1:0] c_d;
  logic [MulW-1:0]        cabs_d;
  pre_t                   pre_d;
  logic                   s4_v_q;
  pre_t                   s4_pre_q;
  logic [MulW-1:0]        s4_cabs_q;

  always_comb begin
    c_d          = $signed({1'b0, s3_ll_q}) - $signed({(MulW - RrW)'(0), s3_rr_q});
    cabs_d       = c_d[MulW-1] ? MulW'(-c_d) : MulW'(c_d);
    pre_d.a_zero = s3_a_q == '0;
    pre_d.h_neg  = s3_h_q[HW-1];
    pre_d.h_pos  = !s3_h_q[HW-1] && (s3_h_q != '0);
    pre_d.c_neg  = c_d[MulW-1];
    pre_d.c_pos  = !c_d[MulW-1] && (c_d != '0);
    pre_d.habs   = s3_h_q[HW-1] ? MulW'(-s3_h_q) : MulW'(s3_h_q);
    pre_d.a      = s3_a_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_pre_q  <= pre_d;
      s4_cabs_q <= cabs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= ray_i.valid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  // h^2 and a*|c|
  logic             m1_v;
  logic [ProdW-1:0] h2;
  logic [ProdW-1:0] ac;
  pre_t             m1_pre;

  rsi_mul #(.W(MulW), .SW($bits(pre_t))) u_mul_hh (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (s4_v_q),
    .x_i    (s4_pre_q.habs),
    .y_i    (s4_pre_q.habs),
    .side_i (s4_pre_q),
    .v_o    (m1_v),
    .p_o    (h2),
    .side_o (m1_pre)
  );

  rsi_mul #(.W(MulW), .SW(1)) u_mul_ac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (s4_v_q),
    .x_i    (MulW'(s4_pre_q.a)),
    .y_i    (s4_cabs_q),
    .side_i (1'b0),
    .v_o    (),
    .p_o    (ac),
    .side_o ()
  );

  // stage 5: discriminant and the miss decision
  logic signed [DiscW-1:0] disc_d;
  logic                    disc_pos;
  sq_side_t                sq_d;
  logic                    s5_v_q;
  logic [RadicW-1:0]       s5_rad_q;
  sq_side_t                s5_side_q;

  always_comb begin
    if (m1_pre.c_neg) begin
      disc_d = $signed({2'b00, h2}) + $signed({2'b00, ac});
    end else begin
      disc_d = $signed({2'b00, h2}) - $signed({2'b00, ac});
    end
    disc_pos   = !disc_d[DiscW-1] && (disc_d != '0);
    sq_d.miss  = m1_pre.a_zero || !disc_pos || (m1_pre.h_pos && m1_pre.c_pos);
    sq_d.near  = m1_pre.h_neg && m1_pre.c_pos;
    sq_d.h_neg = m1_pre.h_neg;
    sq_d.habs  = m1_pre.habs;
    sq_d.a     = m1_pre.a;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_rad_q  <= sq_d.miss ? '0 : disc_d[RadicW-1:0];
      s5_side_q <= sq_d;
    end
  end

  logic             sq_v;
  logic [RootW-1:0] root;
  sq_side_t         sq_side;

  rsi_sqrt #(.RW(RadicW), .SW($bits(sq_side_t))) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (s5_v_q),
    .rad_i  (s5_rad_q),
    .side_i (s5_side_q),
    .v_o    (sq_v),
    .root_o (root),
    .side_o (sq_side)
  );

  // stage 6: numerator of the chosen root, -h - s or -h + s
  logic [MulW-1:0] n_d;
  dist_side_t      ds_d;
  logic            s6_v_q;
  logic [MulW-1:0] s6_n_q;
  dist_side_t      s6_side_q;

  always_comb begin
    if (sq_side.near) begin
      n_d = sq_side.habs - MulW'(root);
    end else if (sq_side.h_neg) begin
      n_d = sq_side.habs + MulW'(root);
    end else begin
      n_d = MulW'(root) - sq_side.habs;
    end
    ds_d.miss = sq_side.miss;
    ds_d.a    = sq_side.a;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_n_q    <= n_d;
      s6_side_q <= ds_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= m1_v;
      s6_v_q <= sq_v;
    end
  end

  logic             m2_v;
  logic [ProdW-1:0] n2;
  dist_side_t       m2_side;

  rsi_mul #(.W(MulW), .SW($bits(dist_side_t))) u_mul_nn (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (s6_v_q),
    .x_i    (s6_n_q),
    .y_i    (s6_n_q),
    .side_i (s6_side_q),
    .v_o    (m2_v),
    .p_o    (n2),
    .side_o (m2_side)
  );

  logic             dist_v;
  logic [DistW-1:0] dist_val;
  logic             dist_miss;

  rsi_dist #(.NW(ProdW), .AW(AW), .DW(DistW), .SW(1)) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (m2_v),
    .n2_i   (n2),
    .a_i    (m2_side.a),
    .side_i (m2_side.miss),
    .v_o    (dist_v),
    .dist_o (dist_val),
    .side_o (dist_miss)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.hit      <= !dist_miss;
      out_q.distance <= dist_miss ? '0 : dist_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dist_v;
    end
  end

  assign res_o.valid = out_v_q;
  assign res_o.data  = out_q;
endmodule

/* sv/rsi_checker.sv */
// port-level checks for the intersection unit, bound to the top level
module rsi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        hit_i,
  input logic [31:0] distance_i
);
  localparam int CntW = 8;

  logic [CntW-1:0] cnt_q;
  logic            in_xfer;
  logic            out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // rays taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CntW'(in_xfer) - CntW'(out_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !hit_i |-> distance_i == '0)
    else $error("miss with non-zero distance");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result with no ray in flight");
endmodule

bind ray_sphere_intersect_unit rsi_checker u_rsi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (ray_i.valid),
  .in_ready_i  (ray_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .hit_i       (res_o.data.hit),
  .distance_i  (res_o.data.distance)
);
